// File: hdl/gvse_pkg.sv
// package with types, constants and helpers for the group varint signed encoder
`timescale 1ns / 1ps

package gvse_pkg;

  localparam int unsigned LimitW         = 17;
  localparam int unsigned BufBytesMaxDef = 65536;
  localparam int unsigned ValueW         = 32;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned GroupN         = 4;

  // input kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // bit positions inside the result tuser
  localparam int unsigned USER_VALID = 0;
  localparam int unsigned USER_EOB   = 1;
  localparam int unsigned USER_OVF   = 2;
  localparam int unsigned UserW      = 3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // minimal two's-complement byte count minus one
  function automatic logic [1:0] code_of(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] s0;
    logic [ValueW-1:0] s1;
    logic [ValueW-1:0] s2;
    s0 = v + 32'h0000_0080;
    s1 = v + 32'h0000_8000;
    s2 = v + 32'h0080_0000;
    if (s0 < 32'h0000_0100) begin
      return 2'd0;
    end else if (s1 < 32'h0001_0000) begin
      return 2'd1;
    end else if (s2 < 32'h0100_0000) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

endpackage

// File: hdl/group_varint_signed_encoder.sv
// top level of the group varint signed encoder
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              tdata = data_value, tuser = kind
// m_axis    out  tvalid/tready              tdata = out_byte, tuser = flags, tlast
// cfg       in   cfg_we_i                   cfg_wdata_i = buffer_limit
//
// a push that does not complete a group, an empty flush or a flush in error is handled without entering the emit state
// a completed group or a padded flush sends one byte per cycle, unless the output stalls,
// through one byte selector, tag then value bytes, input held off meanwhile; an overflow
// ends the group early with its flagged result
// reset clears all state but the result payload registers; held values read as zero, limit is 65536
// a stalled result register holds the sequencer and the input
`timescale 1ns / 1ps

module group_varint_signed_encoder #(
  parameter int unsigned BUFFER_BYTES_MAX = gvse_pkg::BufBytesMaxDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gvse_pkg::ValueW-1:0] s_axis_tdata,   // [31:0] data_value
  input  logic                        s_axis_tuser,   // [0] kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gvse_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [gvse_pkg::UserW-1:0]  m_axis_tuser,   // [0] byte_valid, [1] end_of_buffer, [2] overflow
  output logic                        m_axis_tlast,   // last_of_run
  input  logic                        cfg_we_i,
  input  logic [gvse_pkg::LimitW-1:0] cfg_wdata_i     // buffer_limit
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES_MAX + 1);

  gvse_pkg::state_e state_q, state_d;

  logic [gvse_pkg::LimitW-1:0] limit_q;
  logic [gvse_pkg::ValueW-1:0] held_q [gvse_pkg::GroupN];
  logic [gvse_pkg::ValueW-1:0] held_d [gvse_pkg::GroupN];
  logic [1:0]                  code_q [gvse_pkg::GroupN];
  logic [1:0]                  code_d [gvse_pkg::GroupN];
  logic [1:0]                  cnt_q, cnt_d;
  logic [CntW-1:0]             bytes_q, bytes_d;
  logic                        err_q, err_d;
  logic                        flush_q, flush_d;
  logic                        tag_q, tag_d;
  logic [1:0]                  vi_q, vi_d;
  logic [1:0]                  bi_q, bi_d;

  logic                        out_valid_q, out_valid_d;
  logic [gvse_pkg::ByteW-1:0]  out_data_q, out_data_d;
  logic [gvse_pkg::UserW-1:0]  out_user_q, out_user_d;
  logic                        out_last_q, out_last_d;
  logic                        out_load;

  logic                        out_free;
  logic                        in_acc;
  logic [CntW-1:0]             limit_eff;
  logic                        ovf_hit;
  logic                        final_byte;
  logic [gvse_pkg::ByteW-1:0]  cur_byte;
  logic [gvse_pkg::ByteW-1:0]  tag_byte;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == gvse_pkg::ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    if (32'(limit_q) < 32'(BUFFER_BYTES_MAX)) begin
      limit_eff = CntW'(limit_q);
    end else begin
      limit_eff = CntW'(BUFFER_BYTES_MAX);
    end
  end

  assign ovf_hit    = bytes_q >= limit_eff;
  assign tag_byte   = {code_q[0], code_q[1], code_q[2], code_q[3]};
  assign cur_byte   = tag_q ? tag_byte : held_q[vi_q][{bi_q, 3'b000} +: gvse_pkg::ByteW];
  assign final_byte = !tag_q && (vi_q == 2'd3) && (bi_q == code_q[vi_q]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gvse_pkg::ST_IDLE: begin
        if (in_acc && !err_q) begin
          if (s_axis_tuser == gvse_pkg::KIND_PUSH && cnt_q == 2'd3) begin
            state_d = gvse_pkg::ST_EMIT;
          end else if (s_axis_tuser == gvse_pkg::KIND_FLUSH && cnt_q != 2'd0) begin
            state_d = gvse_pkg::ST_EMIT;
          end
        end
      end
      gvse_pkg::ST_EMIT: begin
        if (out_free && (ovf_hit || final_byte)) begin
          state_d = gvse_pkg::ST_IDLE;
        end
      end
      default: state_d = gvse_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    held_d     = held_q;
    code_d     = code_q;
    cnt_d      = cnt_q;
    bytes_d    = bytes_q;
    err_d      = err_q;
    flush_d    = flush_q;
    tag_d      = tag_q;
    vi_d       = vi_q;
    bi_d       = bi_q;
    out_load   = 1'b0;
    out_data_d = '0;
    out_user_d = '0;
    out_last_d = 1'b0;
    case (state_q)
      gvse_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == gvse_pkg::KIND_PUSH) begin
            if (!err_q) begin
              held_d[cnt_q] = s_axis_tdata;
              code_d[cnt_q] = gvse_pkg::code_of(s_axis_tdata);
              cnt_d         = cnt_q + 2'd1;
              if (cnt_q == 2'd3) begin
                flush_d = 1'b0;
                tag_d   = 1'b1;
                vi_d    = 2'd0;
                bi_d    = 2'd0;
              end
            end
          end else if (!err_q && cnt_q != 2'd0) begin
            flush_d = 1'b1;
            tag_d   = 1'b1;
            vi_d    = 2'd0;
            bi_d    = 2'd0;
            cnt_d   = 2'd0;
          end else begin
            out_load                       = 1'b1;
            out_last_d                     = 1'b1;
            out_user_d[gvse_pkg::USER_EOB] = 1'b1;
            out_user_d[gvse_pkg::USER_OVF] = err_q;
            bytes_d                        = '0;
            err_d                          = 1'b0;
          end
        end
      end
      gvse_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (ovf_hit || final_byte) begin
            out_last_d                     = 1'b1;
            out_user_d[gvse_pkg::USER_EOB] = flush_q;
            for (int i = 0; i < gvse_pkg::GroupN; i++) begin
              held_d[i] = '0;
              code_d[i] = '0;
            end
            cnt_d = 2'd0;
          end
          if (ovf_hit) begin
            out_user_d[gvse_pkg::USER_OVF] = 1'b1;
            err_d                          = !flush_q;
            if (flush_q) begin
              bytes_d = '0;
            end
          end else begin
            out_data_d                       = cur_byte;
            out_user_d[gvse_pkg::USER_VALID] = 1'b1;
            bytes_d                          = flush_q && final_byte ? '0 : bytes_q + 1'b1;
            if (tag_q) begin
              tag_d = 1'b0;
            end else if (bi_q == code_q[vi_q]) begin
              vi_d = vi_q + 2'd1;
              bi_d = 2'd0;
            end else begin
              bi_d = bi_q + 2'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gvse_pkg::ST_IDLE;
      limit_q     <= gvse_pkg::LimitW'(gvse_pkg::BufBytesMaxDef);
      for (int i = 0; i < gvse_pkg::GroupN; i++) begin
        held_q[i] <= '0;
        code_q[i] <= '0;
      end
      cnt_q       <= '0;
      bytes_q     <= '0;
      err_q       <= 1'b0;
      flush_q     <= 1'b0;
      tag_q       <= 1'b0;
      vi_q        <= '0;
      bi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      held_q      <= held_d;
      code_q      <= code_d;
      cnt_q       <= cnt_d;
      bytes_q     <= bytes_d;
      err_q       <= err_d;
      flush_q     <= flush_d;
      tag_q       <= tag_d;
      vi_q        <= vi_d;
      bi_q        <= bi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  // checks
  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gvse_pkg::ST_EMIT |-> !s_axis_tready)
    else $error("input ready while a group is being sent");

  a_ovf_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[gvse_pkg::USER_VALID] && out_user_q[gvse_pkg::USER_OVF]))
    else $error("overflow result carries a byte");

  a_eob_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[gvse_pkg::USER_EOB] |-> out_last_q)
    else $error("end of buffer without tlast");

  a_err_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> cnt_q == 2'd0 && state_q == gvse_pkg::ST_IDLE)
    else $error("values held while in error");

endmodule
